@@ rtl/treatment_cycle_sequencer_defines.svh @@
// Assertion macros shared by the treatment cycle sequencer RTL.
`ifndef TREATMENT_CYCLE_SEQUENCER_DEFINES_SVH
`define TREATMENT_CYCLE_SEQUENCER_DEFINES_SVH

// The consequent must hold at every edge at which the antecedent holds.
`define TCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The expression must hold at every edge outside reset.
`define TCS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

@@ rtl/tcs_pkg.sv @@
// Shared constants and types of the treatment cycle sequencer.
package tcs_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned STEP_W     = 8;
    localparam int unsigned PHASE_W    = 4;

    localparam int unsigned LITE_AERATE_TICKS_DEF = 10;
    localparam int unsigned LITE_PAUSE_TICKS_DEF  = 33600;
    localparam int unsigned TIMER_WIDTH_DEF       = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_PAUSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AERATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DENIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DENIT_FILL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS      = 3'd7;

    localparam logic [CFG_DATA_W-1:0] RST_FILL_PULSE = 24'd30;
    localparam logic [CFG_DATA_W-1:0] RST_FILL_PAUSE = 24'd1800;
    localparam logic [CFG_DATA_W-1:0] RST_AERATE     = 24'd30;
    localparam logic [CFG_DATA_W-1:0] RST_PAUSE      = 24'd30;
    localparam logic [CFG_DATA_W-1:0] RST_DENIT      = 24'd30;
    localparam logic [CFG_DATA_W-1:0] RST_DENIT_FILL = 24'd50;
    localparam logic [CFG_DATA_W-1:0] RST_SETTLE     = 24'd100;
    localparam logic [STEP_W-1:0]     RST_STEPS      = 8'd6;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] fill_pulse;
        logic [CFG_DATA_W-1:0] fill_pause;
        logic [CFG_DATA_W-1:0] aerate;
        logic [CFG_DATA_W-1:0] pause;
        logic [CFG_DATA_W-1:0] denit;
        logic [CFG_DATA_W-1:0] denit_fill;
        logic [CFG_DATA_W-1:0] settle;
        logic [STEP_W-1:0]     steps;
    } t_cfg;

endpackage

@@ rtl/tcs_cfg_regs.sv @@
// Configuration register bank of the treatment cycle sequencer.
module tcs_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0] i_wr_data,
    output tcs_pkg::t_cfg                  o_cfg
);
    import tcs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fill_pulse <= RST_FILL_PULSE;
            r_cfg.fill_pause <= RST_FILL_PAUSE;
            r_cfg.aerate     <= RST_AERATE;
            r_cfg.pause      <= RST_PAUSE;
            r_cfg.denit      <= RST_DENIT;
            r_cfg.denit_fill <= RST_DENIT_FILL;
            r_cfg.settle     <= RST_SETTLE;
            r_cfg.steps      <= RST_STEPS;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_FILL_PULSE: r_cfg.fill_pulse <= i_wr_data;
                CFG_FILL_PAUSE: r_cfg.fill_pause <= i_wr_data;
                CFG_AERATE:     r_cfg.aerate     <= i_wr_data;
                CFG_PAUSE:      r_cfg.pause      <= i_wr_data;
                CFG_DENIT:      r_cfg.denit      <= i_wr_data;
                CFG_DENIT_FILL: r_cfg.denit_fill <= i_wr_data;
                CFG_SETTLE:     r_cfg.settle     <= i_wr_data;
                CFG_STEPS:      r_cfg.steps      <= i_wr_data[STEP_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/treatment_cycle_sequencer.sv @@
// Top level of the treatment cycle sequencer: tick handshake, phase machine and outputs.
// An accepted tick is registered with its level; its result then goes to the output registers.
// One tick beat per cycle unless stalled; the phase update is a single registered pass.
// Reset is synchronous and active low: phase fill pulse, timer and counters zero, no beats held.
// Configuration registers return to their defaults on reset; writes are always accepted.
`include "treatment_cycle_sequencer_defines.svh"

module treatment_cycle_sequencer #(
    parameter int unsigned LITE_AERATE_TICKS = tcs_pkg::LITE_AERATE_TICKS_DEF,
    parameter int unsigned LITE_PAUSE_TICKS  = tcs_pkg::LITE_PAUSE_TICKS_DEF,
    parameter int unsigned TIMER_WIDTH       = tcs_pkg::TIMER_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_level_high,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_aerator_on,
    output logic                           o_sludge_pump_on,
    output logic                           o_decant_pump_on,
    output logic [tcs_pkg::PHASE_W-1:0]    o_phase_code,
    output logic [tcs_pkg::STEP_W-1:0]     o_step_number,
    output logic                           o_cycle_done,
    output logic [tcs_pkg::CFG_DATA_W-1:0] o_decant_length,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcs_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_FILL       = 4'd0,
        PH_FILL_PAUSE = 4'd1,
        PH_LITE_AER   = 4'd2,
        PH_LITE_PAUSE = 4'd3,
        PH_AERATE     = 4'd4,
        PH_PAUSE      = 4'd5,
        PH_DENIT      = 4'd6,
        PH_DENIT_WAIT = 4'd7,
        PH_SETTLE     = 4'd8,
        PH_DECANT     = 4'd9
    } t_phase;

    localparam int unsigned CW = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;
    localparam logic [63:0] TIMER_MAX64 = (64'd1 << TIMER_WIDTH) - 64'd1;
    localparam logic [CW-1:0] TIMER_MAX = CW'(TIMER_MAX64);
    localparam logic [63:0] LITE_AER64 =
        (LITE_AERATE_TICKS == 0) ? 64'd1 : 64'(LITE_AERATE_TICKS);
    localparam logic [CW-1:0] LITE_AER_LEN =
        (LITE_AER64 > TIMER_MAX64) ? TIMER_MAX : CW'(LITE_AER64);
    localparam logic [CW-1:0] LITE_PAUSE_LEN =
        (64'(LITE_PAUSE_TICKS) > TIMER_MAX64) ? TIMER_MAX : CW'(LITE_PAUSE_TICKS);
    localparam logic LITE_PAUSE_ZERO = (LITE_PAUSE_TICKS == 0);

    function automatic logic [CW-1:0] clamp_len(input logic [CFG_DATA_W-1:0] v,
                                                input logic at_least_one);
        logic [CW-1:0] w;
        w = CW'(v);
        if (at_least_one && (w == '0)) begin
            w = CW'(1);
        end
        return (w > TIMER_MAX) ? TIMER_MAX : w;
    endfunction

    t_cfg cfg;

    t_phase                  r_phase, n_phase;
    logic [TIMER_WIDTH-1:0]  r_timer, n_timer;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [1:0]              r_denit, n_denit;
    logic [CFG_DATA_W-1:0]   r_decant, n_decant;

    logic                    r_in_valid;
    logic                    r_level;
    logic                    r_out_valid;
    logic                    r_aer, r_sludge, r_decant_on, r_done;
    logic [PHASE_W-1:0]      r_phase_code;
    logic [STEP_W-1:0]       r_step_out;
    logic [CFG_DATA_W-1:0]   r_len_out;

    logic                    res_aer, res_sludge, res_decant, res_done;
    logic [CFG_DATA_W-1:0]   res_len;

    logic                    in_take, move;
    logic [CW-1:0]           cur_len;
    logic [TIMER_WIDTH-1:0]  tick;
    logic                    expire, adv;
    logic                    z_fp, z_pa, z_dw, z_st, cs_last;
    t_phase                  st_phase, fp_phase, dw_phase;

    tcs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign o_cfg_ready = 1'b1;

    assign move    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    always_comb begin
        unique case (r_phase)
            PH_FILL:       cur_len = clamp_len(cfg.fill_pulse, 1'b1);
            PH_FILL_PAUSE: cur_len = clamp_len(cfg.fill_pause, 1'b0);
            PH_LITE_AER:   cur_len = LITE_AER_LEN;
            PH_LITE_PAUSE: cur_len = LITE_PAUSE_LEN;
            PH_AERATE:     cur_len = clamp_len(cfg.aerate, 1'b1);
            PH_PAUSE:      cur_len = clamp_len(cfg.pause, 1'b0);
            PH_DENIT:      cur_len = clamp_len(cfg.denit, 1'b1);
            PH_DENIT_WAIT: cur_len = clamp_len(cfg.denit_fill, 1'b0);
            PH_SETTLE:     cur_len = clamp_len(cfg.settle, 1'b0);
            default:       cur_len = CW'(1);
        endcase
    end

    assign tick   = r_timer + TIMER_WIDTH'(1);
    assign expire = (tick == '0) || (CW'(tick) >= cur_len);

    assign z_fp    = (cfg.fill_pause == '0);
    assign z_pa    = (cfg.pause == '0);
    assign z_dw    = (cfg.denit_fill == '0);
    assign z_st    = (cfg.settle == '0);
    assign cs_last = ({1'b0, r_step} + (STEP_W + 1)'(1)) >= {1'b0, cfg.steps};

    assign st_phase = z_st ? PH_DECANT : PH_SETTLE;
    assign dw_phase = cs_last ? st_phase : PH_FILL;

    always_comb begin
        priority if (r_step != '0) begin
            fp_phase = PH_AERATE;
        end else if (r_level) begin
            fp_phase = PH_LITE_AER;
        end else if (cfg.steps == '0) begin
            fp_phase = st_phase;
        end else begin
            fp_phase = PH_AERATE;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_step   = r_step;
        n_denit  = r_denit;
        n_decant = r_decant;
        adv      = 1'b0;

        res_aer    = (r_phase == PH_LITE_AER) || (r_phase == PH_AERATE) ||
                     (r_phase == PH_DENIT);
        res_sludge = (r_phase == PH_FILL);
        res_decant = 1'b0;
        res_done   = 1'b0;
        res_len    = '0;

        if (r_phase == PH_DECANT) begin
            if (r_level) begin
                res_done = 1'b1;
                res_len  = r_decant;
                adv      = 1'b1;
            end else begin
                res_decant = 1'b1;
                if (r_decant != '1) begin
                    n_decant = r_decant + CFG_DATA_W'(1);
                end
            end
        end else begin
            n_timer = tick;
            adv     = expire;
        end

        if (adv) begin
            n_timer = '0;
            unique case (r_phase)
                PH_FILL: begin
                    n_phase = z_fp ? fp_phase : PH_FILL_PAUSE;
                    if (z_fp && (fp_phase == PH_AERATE)) begin
                        n_denit = '0;
                    end
                end
                PH_FILL_PAUSE: begin
                    n_phase = fp_phase;
                    if (fp_phase == PH_AERATE) begin
                        n_denit = '0;
                    end
                end
                PH_LITE_AER: begin
                    if (LITE_PAUSE_ZERO) begin
                        n_phase = PH_FILL;
                        n_step  = '0;
                    end else begin
                        n_phase = PH_LITE_PAUSE;
                    end
                end
                PH_AERATE: begin
                    n_denit = '0;
                    n_phase = z_pa ? PH_DENIT : PH_PAUSE;
                end
                PH_PAUSE: n_phase = PH_DENIT;
                PH_DENIT: begin
                    if (r_denit >= 2'd2) begin
                        n_denit = '0;
                        n_phase = z_dw ? dw_phase : PH_DENIT_WAIT;
                        if (z_dw && !cs_last) begin
                            n_step = r_step + STEP_W'(1);
                        end
                    end else begin
                        n_denit = r_denit + 2'd1;
                        n_phase = z_pa ? PH_DENIT : PH_PAUSE;
                    end
                end
                PH_DENIT_WAIT: begin
                    n_phase = dw_phase;
                    if (!cs_last) begin
                        n_step = r_step + STEP_W'(1);
                    end
                end
                PH_SETTLE: n_phase = PH_DECANT;
                default: begin
                    n_phase = PH_FILL;
                    n_step  = '0;
                end
            endcase
            if ((n_phase == PH_DECANT) && (r_phase != PH_DECANT)) begin
                n_decant = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_level <= i_level_high;
        end
        if (move) begin
            r_aer        <= res_aer;
            r_sludge     <= res_sludge;
            r_decant_on  <= res_decant;
            r_done       <= res_done;
            r_phase_code <= r_phase;
            r_step_out   <= r_step;
            r_len_out    <= res_len;
        end
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_FILL;
            r_timer     <= '0;
            r_step      <= '0;
            r_denit     <= '0;
            r_decant    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (move) begin
                r_phase  <= n_phase;
                r_timer  <= n_timer;
                r_step   <= n_step;
                r_denit  <= n_denit;
                r_decant <= n_decant;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_aerator_on     = r_aer;
    assign o_sludge_pump_on = r_sludge;
    assign o_decant_pump_on = r_decant_on;
    assign o_phase_code     = r_phase_code;
    assign o_step_number    = r_step_out;
    assign o_cycle_done     = r_done;
    assign o_decant_length  = r_len_out;

    `TCS_ASSERT_ALWAYS(a_denit_range, i_clk, i_rst_n, r_denit != 2'd3, "denit count out of range")
    `TCS_ASSERT_IMP(a_one_drive, i_clk, i_rst_n, o_valid,
        $onehot0({o_aerator_on, o_sludge_pump_on, o_decant_pump_on}), "two drives on at once")
    `TCS_ASSERT_IMP(a_done_decant, i_clk, i_rst_n, o_valid && o_cycle_done,
        (o_phase_code == PH_DECANT) && !o_decant_pump_on, "cycle end outside decant")
    `TCS_ASSERT_IMP(a_len_done, i_clk, i_rst_n, o_valid && (o_decant_length != '0),
        o_cycle_done, "decant length without cycle end")

endmodule

@@ verif/tb.sv @@
// Self-checking testbench of the treatment cycle sequencer with a beat-accurate phase predictor.
`timescale 1ns / 1ps

module tb;

    typedef enum logic [3:0] {
        PH_FILL       = 4'd0,
        PH_FILL_PAUSE = 4'd1,
        PH_LITE_AER   = 4'd2,
        PH_LITE_PAUSE = 4'd3,
        PH_AERATE     = 4'd4,
        PH_PAUSE      = 4'd5,
        PH_DENIT      = 4'd6,
        PH_DENIT_WAIT = 4'd7,
        PH_SETTLE     = 4'd8,
        PH_DECANT     = 4'd9
    } t_phase;

    typedef struct {
        t_phase      ph;
        logic [23:0] timer;
        logic [7:0]  step;
        logic [1:0]  denit;
        logic [23:0] dcnt;
    } t_seq_state;

    typedef struct packed {
        logic        aerator;
        logic        sludge;
        logic        decant;
        logic [3:0]  phase;
        logic [7:0]  step;
        logic        done;
        logic [23:0] dlen;
    } t_drive_beat;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_stall;
    logic                             i_level_high = 1'b0;
    logic                             o_valid;
    logic                             i_stall = 1'b0;
    logic                             o_aerator_on;
    logic                             o_sludge_pump_on;
    logic                             o_decant_pump_on;
    logic [tcs_pkg::PHASE_W-1:0]      o_phase_code;
    logic [tcs_pkg::STEP_W-1:0]       o_step_number;
    logic                             o_cycle_done;
    logic [tcs_pkg::CFG_DATA_W-1:0]   o_decant_length;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [tcs_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [tcs_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    tcs_pkg::t_cfg regs;
    t_seq_state    st;
    t_drive_beat   want_drives[$];
    int            fails = 0;
    int            src_pct = 0;
    int            snk_pct = 0;
    int            hold_req = 0;
    int            hold_left = 0;

    treatment_cycle_sequencer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_level_high    (i_level_high),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_aerator_on    (o_aerator_on),
        .o_sludge_pump_on(o_sludge_pump_on),
        .o_decant_pump_on(o_decant_pump_on),
        .o_phase_code    (o_phase_code),
        .o_step_number   (o_step_number),
        .o_cycle_done    (o_cycle_done),
        .o_decant_length (o_decant_length),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [23:0] nonzero(logic [23:0] v);
        return (v == 24'd0) ? 24'd1 : v;
    endfunction

    function automatic logic [23:0] phase_len(t_phase p);
        case (p)
            PH_FILL:       return nonzero(regs.fill_pulse);
            PH_FILL_PAUSE: return regs.fill_pause;
            PH_LITE_AER:   return nonzero(24'(tcs_pkg::LITE_AERATE_TICKS_DEF));
            PH_LITE_PAUSE: return 24'(tcs_pkg::LITE_PAUSE_TICKS_DEF);
            PH_AERATE:     return nonzero(regs.aerate);
            PH_PAUSE:      return regs.pause;
            PH_DENIT:      return nonzero(regs.denit);
            PH_DENIT_WAIT: return regs.denit_fill;
            PH_SETTLE:     return regs.settle;
            default:       return 24'd1;
        endcase
    endfunction

    function automatic t_phase successor(t_phase p, logic lvl);
        case (p)
            PH_FILL: return PH_FILL_PAUSE;
            PH_FILL_PAUSE: begin
                if (st.step != 8'd0) begin
                    st.denit = 2'd0;
                    return PH_AERATE;
                end
                if (lvl) return PH_LITE_AER;
                if (regs.steps == 8'd0) return PH_SETTLE;
                st.denit = 2'd0;
                return PH_AERATE;
            end
            PH_LITE_AER: return PH_LITE_PAUSE;
            PH_AERATE: begin
                st.denit = 2'd0;
                return PH_PAUSE;
            end
            PH_PAUSE: return PH_DENIT;
            PH_DENIT: begin
                if (st.denit >= 2'd2) begin
                    st.denit = 2'd0;
                    return PH_DENIT_WAIT;
                end
                st.denit = st.denit + 2'd1;
                return PH_PAUSE;
            end
            PH_DENIT_WAIT: begin
                if (int'(st.step) + 1 >= int'(regs.steps)) return PH_SETTLE;
                st.step = st.step + 8'd1;
                return PH_FILL;
            end
            PH_SETTLE: begin
                st.dcnt = 24'd0;
                return PH_DECANT;
            end
            default: begin
                st.step = 8'd0;
                return PH_FILL;
            end
        endcase
    endfunction

    // Phases of zero length are passed through within the same tick.
    function automatic void leave_phase(logic lvl);
        t_phase p;
        p = successor(st.ph, lvl);
        for (int g = 0; g < 16; g++) begin
            st.ph = p;
            st.timer = 24'd0;
            if (p == PH_DECANT || phase_len(p) != 24'd0) break;
            p = successor(p, lvl);
        end
    endfunction

    function automatic t_drive_beat tick_drives(logic lvl);
        t_drive_beat r;
        t_phase      p;
        p = st.ph;
        r = '0;
        r.aerator = (p == PH_LITE_AER || p == PH_AERATE || p == PH_DENIT);
        r.sludge  = (p == PH_FILL);
        r.phase   = p;
        r.step    = st.step;
        if (p == PH_DECANT) begin
            if (lvl) begin
                r.done = 1'b1;
                r.dlen = st.dcnt;
                leave_phase(lvl);
            end else begin
                r.decant = 1'b1;
                if (st.dcnt != 24'hFFFFFF) st.dcnt = st.dcnt + 24'd1;
            end
        end else begin
            st.timer = st.timer + 24'd1;
            if (st.timer == 24'd0 || st.timer >= phase_len(p)) leave_phase(lvl);
        end
        return r;
    endfunction

    function automatic bit goes_lite();
        t_seq_state saved;
        bit         lite;
        saved = st;
        void'(tick_drives(1'b1));
        lite = (st.ph == PH_LITE_AER);
        st = saved;
        return lite;
    endfunction

    function automatic logic pick_level();
        if (st.ph == PH_DECANT) return ($urandom_range(5) == 0);
        if (goes_lite()) return 1'b0;
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [23:0] short_len();
        if ($urandom_range(11) == 0) return 24'($urandom_range(20, 8));
        return 24'($urandom_range(4, 0));
    endfunction

    function automatic tcs_pkg::t_cfg random_cfg();
        tcs_pkg::t_cfg c;
        c.fill_pulse = short_len();
        c.fill_pause = short_len();
        c.aerate     = short_len();
        c.pause      = short_len();
        c.denit      = short_len();
        c.denit_fill = short_len();
        c.settle     = short_len();
        c.steps      = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(4, 1));
        return c;
    endfunction

    function automatic tcs_pkg::t_cfg filled(logic [23:0] v);
        tcs_pkg::t_cfg c;
        c.fill_pulse = v;
        c.fill_pause = v;
        c.aerate     = v;
        c.pause      = v;
        c.denit      = v;
        c.denit_fill = v;
        c.settle     = v;
        c.steps      = v[7:0];
        return c;
    endfunction

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < snk_pct);
        end
    end

    always @(posedge i_clk) begin
        t_drive_beat w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (want_drives.size() == 0) begin
                $error("result beat with no expected drives");
                fails++;
            end else begin
                w = want_drives.pop_front();
                check_field("aerator_on", 24'(w.aerator), 24'(o_aerator_on));
                check_field("sludge_pump_on", 24'(w.sludge), 24'(o_sludge_pump_on));
                check_field("decant_pump_on", 24'(w.decant), 24'(o_decant_pump_on));
                check_field("phase_code", 24'(w.phase), 24'(o_phase_code));
                check_field("step_number", 24'(w.step), 24'(o_step_number));
                check_field("cycle_done", 24'(w.done), 24'(o_cycle_done));
                check_field("decant_length", w.dlen, o_decant_length);
            end
        end
    end

    task automatic send_tick(logic lvl);
        @(negedge i_clk);
        while ($urandom_range(99) < src_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_level_high <= lvl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want_drives.push_back(tick_drives(lvl));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (want_drives.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(tcs_pkg::t_cfg c);
        logic [2:0]  idx;
        logic [23:0] d;
        wait_drained();
        for (int i = 0; i < 8; i++) begin
            idx = i[2:0];
            case (idx)
                tcs_pkg::CFG_FILL_PULSE: d = c.fill_pulse;
                tcs_pkg::CFG_FILL_PAUSE: d = c.fill_pause;
                tcs_pkg::CFG_AERATE:     d = c.aerate;
                tcs_pkg::CFG_PAUSE:      d = c.pause;
                tcs_pkg::CFG_DENIT:      d = c.denit;
                tcs_pkg::CFG_DENIT_FILL: d = c.denit_fill;
                tcs_pkg::CFG_SETTLE:     d = c.settle;
                default:                 d = {16'($urandom_range(65535)), c.steps};
            endcase
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= d;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
        end
        regs = c;
    endtask

    task automatic send_random(int n);
        for (int k = 0; k < n; k++) send_tick(pick_level());
    endtask

    task automatic run_cycle(int lows);
        int  seen;
        bit  ended;
        logic lvl;
        seen = 0;
        ended = 1'b0;
        for (int n = 0; n < 100000 && !ended; n++) begin
            lvl = 1'b0;
            if (st.ph == PH_DECANT) begin
                lvl = (seen >= lows);
                ended = lvl;
                seen++;
            end
            send_tick(lvl);
        end
    endtask

    task automatic test_zero_lengths();
        tcs_pkg::t_cfg c;
        c = filled(24'd0);
        write_regs(c);
        run_cycle(3);
        c.steps = 8'd2;
        write_regs(c);
        run_cycle(0);
    endtask

    // The light pause is long, so this test runs last and stops a few beats into it.
    task automatic test_lite_mode();
        tcs_pkg::t_cfg c;
        bit seen;
        seen = 1'b0;
        c = random_cfg();
        c.fill_pulse = 24'd2;
        c.fill_pause = 24'd1;
        write_regs(c);
        for (int n = 0; n < 40000 && !seen; n++) begin
            send_tick(goes_lite() ? 1'b1 : logic'($urandom_range(1)));
            if (st.ph == PH_LITE_PAUSE) seen = 1'b1;
        end
        send_random(8);
    endtask

    task automatic test_extreme_regs();
        write_regs(filled(24'hFFFFFF));
        send_random(20);
        write_regs(filled(24'h555555));
        send_random(20);
        write_regs(filled(24'hAAAAAA));
        send_random(20);
    endtask

    task automatic test_long_cycle();
        tcs_pkg::t_cfg c;
        c = filled(24'd0);
        c.fill_pulse = 24'd1;
        c.aerate     = 24'd1;
        c.denit      = 24'd1;
        c.steps      = 8'd64;
        write_regs(c);
        run_cycle(2);
    endtask

    task automatic test_backpressure();
        src_pct = 0;
        snk_pct = 0;
        write_regs(random_cfg());
        hold_req = 60;
        send_random(100);
        wait_drained();
        send_random(30);
    endtask

    task automatic test_random_mix(int src, int snk);
        src_pct = src;
        snk_pct = snk;
        for (int chunk = 0; chunk < 3; chunk++) begin
            write_regs(random_cfg());
            send_random(80);
        end
    endtask

    initial begin
        regs = '{fill_pulse: tcs_pkg::RST_FILL_PULSE, fill_pause: tcs_pkg::RST_FILL_PAUSE,
                 aerate: tcs_pkg::RST_AERATE, pause: tcs_pkg::RST_PAUSE,
                 denit: tcs_pkg::RST_DENIT, denit_fill: tcs_pkg::RST_DENIT_FILL,
                 settle: tcs_pkg::RST_SETTLE, steps: tcs_pkg::RST_STEPS};
        st = '{ph: PH_FILL, timer: 24'd0, step: 8'd0, denit: 2'd0, dcnt: 24'd0};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_lengths();
        test_extreme_regs();
        test_long_cycle();
        test_backpressure();
        test_random_mix(0, 0);
        test_random_mix(64, 0);
        test_random_mix(0, 64);
        test_random_mix(7, 7);
        src_pct = 0;
        snk_pct = 0;
        test_lite_mode();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (want_drives.size() != 0) begin
            $error("%0d expected result beats never arrived", want_drives.size());
            fails++;
        end
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tcs_pkg.sv
rtl/tcs_cfg_regs.sv
rtl/treatment_cycle_sequencer.sv
verif/tb.sv
